// ===== hw/rtl/lidar_ttc_emergency_brake_unit_macros.svh =====
// Assertion macros used by the brake unit controller.
`ifndef LIDAR_TTC_EMERGENCY_BRAKE_UNIT_MACROS_SVH
`define LIDAR_TTC_EMERGENCY_BRAKE_UNIT_MACROS_SVH
// Condition in this cycle implies consequence in this cycle.
`define TTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttc: same-cycle check failed");
// Condition in this cycle implies consequence in the next cycle.
`define TTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttc: next-cycle check failed");
`endif

// ===== hw/rtl/ttc_pkg.sv =====
// Package: constants, types and helper functions of the brake unit.
`default_nettype none
package ttc_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W = $clog2(24);

  localparam logic signed [19:0] ANG_PI      = 20'sd205887;
  localparam logic signed [19:0] ANG_HALF_PI = 20'sd102944;
  localparam logic signed [19:0] ANG_TWO_PI  = 20'sd411775;
  localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;

  localparam logic [2:0] REG_ANGLE_START = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
  localparam logic [2:0] REG_CAR_WIDTH   = 3'd2;
  localparam logic [2:0] REG_DECEL       = 3'd3;
  localparam logic [2:0] REG_RANGE_MAX   = 3'd4;

  typedef struct packed {
    logic load;
    logic prep;
    logic iter;
    logic mul1;
    logic mul2;
    logic decide;
    logic emit;
  } ttc_cmd_t;

  typedef struct packed {
    logic is_beam;
    logic last;
    logic iter_last;
    logic out_free;
  } ttc_stat_t;

  // atan(2^-i) in Q16, rounded to nearest
  function automatic logic [16:0] atan_q16(input logic [CNT_W-1:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:  v = 17'd51472;
      5'd1:  v = 17'd30385;
      5'd2:  v = 17'd16055;
      5'd3:  v = 17'd8150;
      5'd4:  v = 17'd4091;
      5'd5:  v = 17'd2047;
      5'd6:  v = 17'd1024;
      5'd7:  v = 17'd512;
      5'd8:  v = 17'd256;
      5'd9:  v = 17'd128;
      5'd10: v = 17'd64;
      5'd11: v = 17'd32;
      5'd12: v = 17'd16;
      5'd13: v = 17'd8;
      5'd14: v = 17'd4;
      5'd15: v = 17'd2;
      5'd16: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // one conditional add or subtract of 2*pi
  function automatic logic signed [18:0] wrap_angle(input logic signed [19:0] a);
    logic signed [19:0] r;
    if (a > ANG_PI) begin
      r = a - ANG_TWO_PI;
    end else if (a < -ANG_PI) begin
      r = a + ANG_TWO_PI;
    end else begin
      r = a;
    end
    return r[18:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ttc_if.sv =====
// Handshake interfaces: beam/odometry input, brake result, config write.
`default_nettype none
interface ttc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic signed [15:0] speed_mm_s;
  logic [15:0] range_mm;
  logic        last_beam;
  modport source (output valid, kind, speed_mm_s, range_mm, last_beam, input ready);
  modport sink   (input valid, kind, speed_mm_s, range_mm, last_beam, output ready);
endinterface

interface ttc_out_if;
  logic        valid;
  logic        ready;
  logic        brake_active;
  logic        brake_command;
  logic [31:0] brake_sequence;
  modport source (output valid, brake_active, brake_command, brake_sequence, input ready);
  modport sink   (input valid, brake_active, brake_command, brake_sequence, output ready);
endinterface

interface ttc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [18:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ttc_ctrl.sv =====
// Controller: sequences load, CORDIC iterations, tests and result emission.
`default_nettype none
`include "lidar_ttc_emergency_brake_unit_macros.svh"
module ttc_ctrl
  import ttc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ttc_stat_t stat,
  output ttc_cmd_t       cmd
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_ITER   = 7'b0000100,
    S_MUL1   = 7'b0001000,
    S_MUL2   = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.is_beam) state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (stat.iter_last) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // wait for the output word slot to free up
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TTC_ASSERT_NEXT(a_beam_starts, in_valid && in_ready && stat.is_beam, state_r == S_PREP)
  `TTC_ASSERT_NEXT(a_iter_ends, state_r == S_ITER && stat.iter_last, state_r == S_MUL1)
  `TTC_ASSERT_NEXT(a_emit_holds, state_r == S_EMIT && !stat.out_free, state_r == S_EMIT)
endmodule
`default_nettype wire

// ===== hw/rtl/ttc_datapath.sv =====
// Datapath: config registers, scan state, CORDIC, hazard tests, output word.
`default_nettype none
module ttc_datapath
  import ttc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ttc_cmd_t    cmd,
  output ttc_stat_t        stat,
  input  wire logic        in_kind,
  input  wire logic signed [15:0] in_speed_mm_s,
  input  wire logic [15:0] in_range_mm,
  input  wire logic        in_last_beam,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [18:0] cfg_data,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic             out_brake_active,
  output logic             out_brake_command,
  output logic [31:0]      out_brake_sequence
);
  // configuration
  logic signed [18:0] ang_start_r;
  logic [16:0] ang_step_r;
  logic [11:0] width_r;
  logic [15:0] decel_r, rmax_r;

  // scan state
  logic signed [15:0] speed_r;
  logic signed [18:0] beam_ang_r, cur_ang_r;
  logic mid_scan_r, hazard_r, brake_r;
  logic [31:0] count_r;

  // item and CORDIC
  logic [15:0] range_r;
  logic last_r;
  logic signed [19:0] x_r, y_r, z_r;
  logic neg_r;
  logic [CNT_W-1:0] cnt_r;

  // products
  logic [31:0] p_rd_r;
  logic [30:0] p_ss_r;
  logic [32:0] p_rs_r;
  logic [47:0] p_sc_r;
  logic [16:0] ac_r;
  logic ahead_r, s_zero_r;

  // output word
  logic out_valid_r, out_cmd_r;
  logic [31:0] out_seq_r;

  logic signed [19:0] ang_sel, dx, dy, atan_s, c_val, s_val, c_abs, s_abs;
  logic signed [31:0] sp_sq;
  logic in_corr, stop, beam_haz, brk;

  assign stat.is_beam   = in_kind;
  assign stat.last      = last_r;
  assign stat.iter_last = (cnt_r == CNT_W'(CORDIC_STEPS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    ang_sel = mid_scan_r ? 20'(beam_ang_r) : 20'(wrap_angle(20'(ang_start_r)));
    dx      = y_r >>> cnt_r;
    dy      = x_r >>> cnt_r;
    atan_s  = $signed({3'b000, atan_q16(cnt_r)});
    c_val   = neg_r ? -x_r : x_r;
    s_val   = neg_r ? -y_r : y_r;
    c_abs   = c_val[19] ? -c_val : c_val;
    s_abs   = s_val[19] ? -s_val : s_val;
    sp_sq   = speed_r * speed_r;
    in_corr = s_zero_r ? ((width_r != 12'd0) || (range_r < rmax_r))
                       : ({p_rs_r, 1'b0} < {6'd0, width_r, 16'd0});
    stop    = {p_rd_r, 16'd0} < p_sc_r;
    beam_haz = ahead_r && in_corr && stop;
    brk     = (speed_r != 16'sd0) && hazard_r;
  end

  // config and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_start_r <= -19'sd154415;
      ang_step_r  <= 17'd285;
      width_r     <= 12'd400;
      decel_r     <= 16'd5760;
      rmax_r      <= 16'd30000;
      speed_r     <= '0;
      beam_ang_r  <= '0;
      mid_scan_r  <= 1'b0;
      hazard_r    <= 1'b0;
      brake_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ANGLE_START: ang_start_r <= $signed(cfg_data);
          REG_ANGLE_STEP:  ang_step_r  <= cfg_data[16:0];
          REG_CAR_WIDTH:   width_r     <= cfg_data[11:0];
          REG_DECEL:       decel_r     <= cfg_data[15:0];
          REG_RANGE_MAX:   rmax_r      <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load && !in_kind) speed_r <= in_speed_mm_s;
      if (cmd.prep && !mid_scan_r) hazard_r <= 1'b0;
      if (cmd.decide) begin
        hazard_r <= hazard_r | beam_haz;
        if (!last_r) begin
          mid_scan_r <= 1'b1;
          beam_ang_r <= wrap_angle(20'(cur_ang_r) + $signed({3'b000, ang_step_r}));
        end
      end
      // a new word may replace the one leaving in the same cycle
      if (cmd.emit) begin
        brake_r     <= brk;
        if (brk) count_r <= count_r + 32'd1;
        mid_scan_r  <= 1'b0;
        hazard_r    <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: item latch, CORDIC, products, output word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      range_r <= in_range_mm;
      last_r  <= in_last_beam;
    end
    if (cmd.prep) begin
      cur_ang_r <= ang_sel[18:0];
      x_r       <= CORDIC_GAIN;
      y_r       <= '0;
      cnt_r     <= '0;
      if (ang_sel > ANG_HALF_PI) begin
        z_r <= ang_sel - ANG_PI;  neg_r <= 1'b1;
      end else if (ang_sel < -ANG_HALF_PI) begin
        z_r <= ang_sel + ANG_PI;  neg_r <= 1'b1;
      end else begin
        z_r <= ang_sel;           neg_r <= 1'b0;
      end
    end
    if (cmd.iter) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (!z_r[19]) begin
        x_r <= x_r - dx;  y_r <= y_r + dy;  z_r <= z_r - atan_s;
      end else begin
        x_r <= x_r + dx;  y_r <= y_r - dy;  z_r <= z_r + atan_s;
      end
    end
    if (cmd.mul1) begin
      p_rd_r   <= range_r * decel_r;
      p_ss_r   <= sp_sq[30:0];
      p_rs_r   <= range_r * s_abs[16:0];
      ac_r     <= c_abs[16:0];
      s_zero_r <= (s_val == 20'sd0);
      ahead_r  <= (speed_r > 16'sd0 && c_val > 20'sd0) ||
                  (speed_r < 16'sd0 && c_val < 20'sd0);
    end
    if (cmd.mul2) p_sc_r <= p_ss_r * ac_r;
    if (cmd.emit) begin
      out_cmd_r <= brk;
      out_seq_r <= brk ? count_r + 32'd1 : count_r;
    end
  end

  // brake state is held until the next scan ends
  assign out_valid          = out_valid_r;
  assign out_brake_active   = brake_r;
  assign out_brake_command  = out_cmd_r;
  assign out_brake_sequence = out_seq_r;
endmodule
`default_nettype wire

// ===== hw/rtl/lidar_ttc_emergency_brake_unit.sv =====
// Top level: lidar time-to-collision emergency brake unit.
// Channels: in_ch takes words of two kinds. kind 0 latches speed_mm_s and
//   leaves the unit idle; kind 1 is one beam range, last_beam marks the scan end.
// After a beam is accepted it passes the prep step, the iterative CORDIC loop
//   (one rotation per cycle), two multiply stages and the decision before the
//   next word can be taken; a last beam also passes the emit step.
// On the last beam one word leaves on out_ch: brake_active, brake_command and
//   brake_sequence (command count), registered in the emit step after the decision.
// While a result waits for out_ch.ready the next input words are still taken;
//   a following last beam holds in the emit step until the output slot frees.
// cfg_ch writes register index 0..4 (angle start, step, car width, decel,
//   range max); ready is always high, writes to other indexes are dropped.
// Reset (rst_n low, synchronous) restores register defaults, clears speed,
//   scan state, brake state and command count; no clearing pass is needed.
`default_nettype none
module lidar_ttc_emergency_brake_unit
  import ttc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  ttc_in_if.sink    in_ch,
  ttc_out_if.source out_ch,
  ttc_cfg_if.sink   cfg_ch
);
  ttc_cmd_t  cmd;
  ttc_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  ttc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ttc_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_ch.kind),
    .in_speed_mm_s      (in_ch.speed_mm_s),
    .in_range_mm        (in_ch.range_mm),
    .in_last_beam       (in_ch.last_beam),
    .cfg_we             (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_brake_active   (out_ch.brake_active),
    .out_brake_command  (out_ch.brake_command),
    .out_brake_sequence (out_ch.brake_sequence)
  );
endmodule
`default_nettype wire
